/* hdl/cgce_pkg.sv */
// ----------------------------------------------------------------------------
// cgce_pkg: shared types and constants for the composite glyph encoder
// Holds the flag bit codes, the byte argument limits, the queue depth and the
// item type that travels from the front to the back through the queue.
// ----------------------------------------------------------------------------
package cgce_pkg;

    // Component record flag bits
    localparam logic [15:0] FLAG_WORDS     = 16'h0001;
    localparam logic [15:0] FLAG_XY_VALUES = 16'h0002;
    localparam logic [15:0] FLAG_SCALE     = 16'h0008;
    localparam logic [15:0] FLAG_MORE      = 16'h0020;
    localparam logic [15:0] FLAG_XY_SCALE  = 16'h0040;
    localparam logic [15:0] FLAG_UNSCALED  = 16'h1000;

    // Range of an offset that still fits a byte argument
    localparam logic signed [15:0] ARG_BYTE_MAX = 16'sd127;
    localparam logic signed [15:0] ARG_BYTE_MIN = -16'sd128;

    // F2Dot14 fraction bits and the rounding bias for truncation toward zero
    localparam int                 FRAC_BITS = 14;
    localparam logic signed [31:0] FRAC_BIAS = 32'sd16383;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Classified component with its four corner products
    typedef struct packed {
        logic [15:0]        flags;
        logic [15:0]        glyph;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [31:0] prod_x_min;
        logic signed [31:0] prod_y_min;
        logic signed [31:0] prod_x_max;
        logic signed [31:0] prod_y_max;
        logic               last;
    } comp_item_t;

    // Finished component record with the union box
    typedef struct packed {
        logic [15:0]        flags;
        logic signed [15:0] arg_x;
        logic signed [15:0] arg_y;
        logic signed [15:0] transform_x;
        logic signed [15:0] transform_y;
        logic [15:0]        glyph_out;
        logic signed [15:0] union_x_min;
        logic signed [15:0] union_y_min;
        logic signed [15:0] union_x_max;
        logic signed [15:0] union_y_max;
        logic               done;
    } comp_result_t;

endpackage

/* hdl/cgce_front.sv */
// ----------------------------------------------------------------------------
// cgce_front: component classifier
// Builds the flag word of an incoming component and forms the four corner
// products edge * scale, which the queue registers on the transfer.
// ----------------------------------------------------------------------------
module cgce_front
    import cgce_pkg::*;
(
    input  logic [15:0]        glyph,
    input  logic signed [15:0] child_x_min,
    input  logic signed [15:0] child_y_min,
    input  logic signed [15:0] child_x_max,
    input  logic signed [15:0] child_y_max,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [15:0] offset_x,
    input  logic signed [15:0] offset_y,
    input  logic               last,
    output comp_item_t         item
);

    logic words_needed;

    // Offsets outside the byte range need word arguments
    assign words_needed = (offset_x > ARG_BYTE_MAX) || (offset_x < ARG_BYTE_MIN) ||
                          (offset_y > ARG_BYTE_MAX) || (offset_y < ARG_BYTE_MIN);

    // Flag word and corner products
    always_comb begin
        item.flags = FLAG_XY_VALUES | FLAG_UNSCALED;
        item.flags = item.flags | ((scale_x == scale_y) ? FLAG_SCALE : FLAG_XY_SCALE);
        if (!last) begin
            item.flags = item.flags | FLAG_MORE;
        end
        if (words_needed) begin
            item.flags = item.flags | FLAG_WORDS;
        end
        item.glyph      = glyph;
        item.offset_x   = offset_x;
        item.offset_y   = offset_y;
        item.scale_x    = scale_x;
        item.scale_y    = scale_y;
        item.prod_x_min = 32'(child_x_min) * 32'(scale_x);
        item.prod_y_min = 32'(child_y_min) * 32'(scale_y);
        item.prod_x_max = 32'(child_x_max) * 32'(scale_x);
        item.prod_y_max = 32'(child_y_max) * 32'(scale_y);
        item.last       = last;
    end

endmodule

/* hdl/cgce_queue.sv */
// ----------------------------------------------------------------------------
// cgce_queue: front-to-back component queue
// Short first-in first-out buffer that lets the classifier and the box
// update stall independently.
// ----------------------------------------------------------------------------
module cgce_queue
    import cgce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  comp_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output comp_item_t out_item
);

    comp_item_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push, pop;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hdl/cgce_back.sv */
// ----------------------------------------------------------------------------
// cgce_back: box placement and union update
// Scales each corner product down with truncation toward zero, adds the
// offset, merges the result into the running union box and holds the record
// in the output register.
// ----------------------------------------------------------------------------
module cgce_back
    import cgce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  comp_item_t   in_item,
    output logic         out_valid,
    input  logic         out_ready,
    output comp_result_t out_result
);

    logic signed [15:0] box_left_reg, box_left_next;
    logic signed [15:0] box_bottom_reg, box_bottom_next;
    logic signed [15:0] box_right_reg, box_right_next;
    logic signed [15:0] box_top_reg, box_top_next;
    logic               starting_new_reg;
    logic               valid_reg;
    comp_result_t       result_reg, result_next;
    logic signed [15:0] new_left, new_bottom, new_right, new_top;
    logic               take;

    // Divide by 16384 toward zero, add offset, wrap to 16 bits
    function automatic logic signed [15:0] place_edge(input logic signed [31:0] prod,
                                                      input logic signed [15:0] off);
        logic signed [31:0] biased;
        logic signed [31:0] quot;
        biased = prod + (prod[31] ? FRAC_BIAS : 32'sd0);
        quot   = biased >>> FRAC_BITS;
        return quot[15:0] + off;
    endfunction

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    assign new_left   = place_edge(in_item.prod_x_min, in_item.offset_x);
    assign new_bottom = place_edge(in_item.prod_y_min, in_item.offset_y);
    assign new_right  = place_edge(in_item.prod_x_max, in_item.offset_x);
    assign new_top    = place_edge(in_item.prod_y_max, in_item.offset_y);

    // Union merge: a new glyph restarts the box
    always_comb begin
        box_left_next   = (starting_new_reg || box_left_reg > new_left) ?
                          new_left : box_left_reg;
        box_bottom_next = (starting_new_reg || box_bottom_reg > new_bottom) ?
                          new_bottom : box_bottom_reg;
        box_right_next  = (starting_new_reg || box_right_reg < new_right) ?
                          new_right : box_right_reg;
        box_top_next    = (starting_new_reg || box_top_reg < new_top) ?
                          new_top : box_top_reg;
    end

    // Record assembly
    always_comb begin
        result_next.flags       = in_item.flags;
        result_next.arg_x       = in_item.offset_x;
        result_next.arg_y       = in_item.offset_y;
        result_next.transform_x = in_item.scale_x;
        result_next.transform_y = in_item.scale_y;
        result_next.glyph_out   = in_item.glyph;
        result_next.union_x_min = box_left_next;
        result_next.union_y_min = box_bottom_next;
        result_next.union_x_max = box_right_next;
        result_next.union_y_max = box_top_next;
        result_next.done        = in_item.last;
    end

    // Union state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg     <= '0;
            box_bottom_reg   <= '0;
            box_right_reg    <= '0;
            box_top_reg      <= '0;
            starting_new_reg <= 1'b1;
            valid_reg        <= 1'b0;
        end else begin
            if (take) begin
                box_left_reg     <= box_left_next;
                box_bottom_reg   <= box_bottom_next;
                box_right_reg    <= box_right_next;
                box_top_reg      <= box_top_next;
                starting_new_reg <= in_item.last;
                valid_reg        <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

/* hdl/composite_glyph_component_encoder.sv */
// ----------------------------------------------------------------------------
// composite_glyph_component_encoder: composite glyph component record encoder
// An input passes through the queue entry register and then the output
// register, which raises m_tvalid when the back is free.
// Throughput: one component per cycle while m_tready holds high, set by the
// single union box update. Reset clears the queue and the output valid, zeroes
// the union box and marks the next component as the first of a new glyph.
// ----------------------------------------------------------------------------
module composite_glyph_component_encoder
    import cgce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // component_glyph, child_x_min, child_y_min, child_x_max, child_y_max,
    // scale_x, scale_y, offset_x, offset_y
    input  logic [143:0] s_tdata,
    input  logic         s_tlast,      // last_component
    output logic         m_tvalid,
    input  logic         m_tready,
    // component_flags, arg_x, arg_y, transform_x, transform_y, glyph_out,
    // union_x_min, union_y_min, union_x_max, union_y_max
    output logic [159:0] m_tdata,
    output logic         m_tlast       // composite_done
);

    comp_item_t   front_item, queue_item;
    logic         queue_valid, back_ready;
    comp_result_t result;

    cgce_front u_front (
        .glyph       (s_tdata[15:0]),
        .child_x_min (s_tdata[31:16]),
        .child_y_min (s_tdata[47:32]),
        .child_x_max (s_tdata[63:48]),
        .child_y_max (s_tdata[79:64]),
        .scale_x     (s_tdata[95:80]),
        .scale_y     (s_tdata[111:96]),
        .offset_x    (s_tdata[127:112]),
        .offset_y    (s_tdata[143:128]),
        .last        (s_tlast),
        .item        (front_item)
    );

    cgce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_item  (queue_item)
    );

    cgce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (back_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the record, first field lowest
    assign m_tdata = {result.union_y_max, result.union_x_max, result.union_y_min,
                      result.union_x_min, result.glyph_out, result.transform_y,
                      result.transform_x, result.arg_y, result.arg_x, result.flags};
    assign m_tlast = result.done;

endmodule
